/* rtl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types, widths and the colour scaling function of the antialiased
// line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 24;
   localparam int FRAC_W  = 16;
   localparam int ACC_W   = COORD_W + FRAC_W;
   localparam int MAG_W   = FRAC_W + 1;
   localparam int WGT_W   = 9;
   localparam int DIV_CNT_W = 5;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;
   localparam logic [WGT_W-1:0]   WGT_FULL    = 9'd256;
   localparam logic [WGT_W-1:0]   WGT_HALF    = 9'd128;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COLOR_W-1:0] color_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic same;
      logic axis;
      logic div_done;
      logic last;
   } status_type;

   function automatic color_type scale_color(color_type c, logic [WGT_W-1:0] w);
      logic [16:0] r;
      logic [16:0] g;
      logic [16:0] b;
      r = c[23:16] * w;
      g = c[15:8] * w;
      b = c[7:0] * w;
      return {r[15:8], g[15:8], b[15:8]};
   endfunction

endpackage

/* rtl/antialiased_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style antialiased line rasterizer emitting one pixel-pair beat per step.
//
//   channel  ports           handshake
//   request  req_*           start high while busy low
//   result   rsp_*           rsp_strobe, one cycle, no back-pressure
//   config   csr_*           csr_valid and csr_ready
//
// A sloped line is accepted, passes through the bit-serial gradient divider
// and then gives one result beat per cycle, da + 1 beats in all.
// Axis-aligned lines skip the divider and give one beat per cycle.
// Identical endpoints give no beat and busy stays low.
// Reset is synchronous and restores the color to white.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer #(
   parameter int SCREEN_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  alr_pkg::coord_type req_x_start,
   input  alr_pkg::coord_type req_y_start,
   input  alr_pkg::coord_type req_x_end,
   input  alr_pkg::coord_type req_y_end,
   output logic               rsp_strobe,
   output alr_pkg::coord_type rsp_first_x,
   output alr_pkg::coord_type rsp_first_y,
   output alr_pkg::color_type rsp_first_color,
   output logic               rsp_first_valid,
   output alr_pkg::coord_type rsp_second_x,
   output alr_pkg::coord_type rsp_second_y,
   output alr_pkg::color_type rsp_second_color,
   output logic               rsp_second_valid,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  alr_pkg::color_type csr_line_color
);
   import alr_pkg::*;

   cmd_type    cmd;
   status_type status;
   color_type  color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         color_ff <= csr_line_color;
      end
   end

   assign csr_ready = 1'b1;

   alr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   alr_dp #(
      .SCREEN_SIZE (SCREEN_SIZE)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .x_start      (req_x_start),
      .y_start      (req_y_start),
      .x_end        (req_x_end),
      .y_end        (req_y_end),
      .color        (color_ff),
      .strobe       (rsp_strobe),
      .first_x      (rsp_first_x),
      .first_y      (rsp_first_y),
      .first_color  (rsp_first_color),
      .first_valid  (rsp_first_valid),
      .second_x     (rsp_second_x),
      .second_y     (rsp_second_y),
      .second_color (rsp_second_color),
      .second_valid (rsp_second_valid),
      .last         (rsp_last)
   );

endmodule

/* rtl/alr_div.sv */
// ----------------------------------------------------------------------------
// alr_div
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module alr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [alr_pkg::ACC_W-1:0]  numer,
   input  logic [alr_pkg::COORD_W-1:0] denom,
   output logic                       done,
   output logic [alr_pkg::MAG_W-1:0]  quot
);
   import alr_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]     num_ff, num_in;
   logic [ACC_W-1:0]     q_ff, q_in;
   logic [COORD_W-1:0]   den_ff, den_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [COORD_W:0]     trial;
   logic [COORD_W:0]     diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, num_ff[ACC_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(ACC_W - 1);
         num_in = numer;
         den_in = denom;
         rem_in = '0;
         q_in   = '0;
      end else if (run_ff) begin
         num_in = {num_ff[ACC_W-2:0], 1'b0};
         rem_in = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         q_in   = {q_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = q_ff[MAG_W-1:0];

endmodule

/* rtl/alr_dp.sv */
// ----------------------------------------------------------------------------
// alr_dp
// Datapath: endpoint ordering, gradient division, minor-axis accumulator,
// coverage weights and the registered result beat.
// ----------------------------------------------------------------------------
module alr_dp #(
   parameter int SCREEN_SIZE = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  alr_pkg::cmd_type     cmd,
   output alr_pkg::status_type  status,
   input  alr_pkg::coord_type   x_start,
   input  alr_pkg::coord_type   y_start,
   input  alr_pkg::coord_type   x_end,
   input  alr_pkg::coord_type   y_end,
   input  alr_pkg::color_type   color,
   output logic                 strobe,
   output alr_pkg::coord_type   first_x,
   output alr_pkg::coord_type   first_y,
   output alr_pkg::color_type   first_color,
   output logic                 first_valid,
   output alr_pkg::coord_type   second_x,
   output alr_pkg::coord_type   second_y,
   output alr_pkg::color_type   second_color,
   output logic                 second_valid,
   output logic                 last
);
   import alr_pkg::*;

   localparam logic [COORD_W:0] SCREEN_LIM = (COORD_W+1)'(SCREEN_SIZE);

   coord_type adx, ady, a1o, a2o, b1o, b2o, ta1, ta2, tb1, tb2, da, adb, lo, hi;
   logic      xmaj, vert, neg;

   coord_type a_ff, a_in, a_first_ff, a_end_ff, b1_ff, b2_ff;
   logic      xmaj_ff, axis_ff, neg_ff;
   logic [ACC_W-1:0] acc_ff, acc_in, g;
   logic [MAG_W-1:0] mag;
   logic      div_done;

   coord_type pos;
   logic [COORD_W:0] pos1;
   logic      endpt;
   logic [WGT_W-1:0] w1, w2;
   coord_type f_x, f_y, s_x, s_y;
   logic [COORD_W:0] s_x7, s_y7;
   logic      f_v, s_v;

   logic      strobe_ff;
   coord_type fx_ff, fy_ff, sx_ff, sy_ff;
   color_type fc_ff, sc_ff;
   logic      fv_ff, sv_ff, last_ff;

   always_comb begin
      adx  = (x_end > x_start) ? x_end - x_start : x_start - x_end;
      ady  = (y_end > y_start) ? y_end - y_start : y_start - y_end;
      xmaj = ady < adx;
      vert = x_start == x_end;
      ta1  = xmaj ? x_start : y_start;
      tb1  = xmaj ? y_start : x_start;
      ta2  = xmaj ? x_end : y_end;
      tb2  = xmaj ? y_end : x_end;
      if (ta1 > ta2) begin
         a1o = ta2; b1o = tb2; a2o = ta1; b2o = tb1;
      end else begin
         a1o = ta1; b1o = tb1; a2o = ta2; b2o = tb2;
      end
      da  = a2o - a1o;
      neg = b2o < b1o;
      adb = neg ? b1o - b2o : b2o - b1o;
      lo  = vert ? ((y_start < y_end) ? y_start : y_end)
                 : ((x_start < x_end) ? x_start : x_end);
      hi  = vert ? ((y_start < y_end) ? y_end : y_start)
                 : ((x_start < x_end) ? x_end : x_start);
   end

   alr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer ({adb, {FRAC_W{1'b0}}}),
      .denom (da),
      .done  (div_done),
      .quot  (mag)
   );

   always_comb begin
      g = neg_ff ? ACC_W'(-{{(ACC_W-MAG_W){1'b0}}, mag})
                 : {{(ACC_W-MAG_W){1'b0}}, mag};
      endpt = (a_ff == a_first_ff) || (a_ff == a_end_ff);
      if (axis_ff || a_ff == a_first_ff) begin
         pos = b1_ff;
      end else if (a_ff == a_end_ff) begin
         pos = b2_ff;
      end else begin
         pos = acc_ff[ACC_W-1:FRAC_W];
      end
      if (axis_ff) begin
         w2 = '0;
         w1 = WGT_FULL;
      end else if (endpt) begin
         w2 = '0;
         w1 = WGT_HALF;
      end else begin
         w2 = {1'b0, acc_ff[FRAC_W-1:FRAC_W-8]};
         w1 = WGT_FULL - w2;
      end
      pos1 = {1'b0, pos} + 1'b1;
      f_x  = xmaj_ff ? a_ff : pos;
      f_y  = xmaj_ff ? pos : a_ff;
      s_x7 = xmaj_ff ? {1'b0, a_ff} : pos1;
      s_y7 = xmaj_ff ? pos1 : {1'b0, a_ff};
      s_x  = s_x7[COORD_W-1:0];
      s_y  = s_y7[COORD_W-1:0];
      f_v  = ({1'b0, f_x} < SCREEN_LIM) && ({1'b0, f_y} < SCREEN_LIM);
      s_v  = (s_x7 < SCREEN_LIM) && (s_y7 < SCREEN_LIM);
      a_in   = a_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         a_in   = vert || (y_start == y_end) ? lo : a1o;
         acc_in = {b1o, {FRAC_W{1'b0}}};
      end else if (cmd.emit) begin
         a_in   = a_ff + 1'b1;
         acc_in = acc_ff + g;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         axis_ff    <= vert || (y_start == y_end);
         a_first_ff <= a1o;
         if (vert || (y_start == y_end)) begin
            a_end_ff <= hi - 1'b1;
            b1_ff    <= vert ? x_start : y_start;
            xmaj_ff  <= !vert;
         end else begin
            a_end_ff <= a2o;
            b1_ff    <= b1o;
            xmaj_ff  <= xmaj;
         end
         b2_ff  <= b2o;
         neg_ff <= neg;
      end
      if (cmd.emit) begin
         fx_ff   <= f_x;
         fy_ff   <= f_y;
         fc_ff   <= scale_color(color, w1);
         fv_ff   <= f_v;
         sx_ff   <= axis_ff ? '0 : s_x;
         sy_ff   <= axis_ff ? '0 : s_y;
         sc_ff   <= axis_ff ? '0 : scale_color(color, w2);
         sv_ff   <= !axis_ff && s_v;
         last_ff <= a_ff == a_end_ff;
      end
   end

   assign status.same     = (x_start == x_end) && (y_start == y_end);
   assign status.axis     = (x_start == x_end) || (y_start == y_end);
   assign status.div_done = div_done;
   assign status.last     = a_ff == a_end_ff;

   assign strobe       = strobe_ff;
   assign first_x      = fx_ff;
   assign first_y      = fy_ff;
   assign first_color  = fc_ff;
   assign first_valid  = fv_ff;
   assign second_x     = sx_ff;
   assign second_y     = sy_ff;
   assign second_color = sc_ff;
   assign second_valid = sv_ff;
   assign last         = last_ff;

endmodule

/* rtl/alr_ctrl.sv */
// ----------------------------------------------------------------------------
// alr_ctrl
// Controller: accepts a line command, waits for the gradient division on
// sloped lines and steps the run one result beat per cycle.
// ----------------------------------------------------------------------------
module alr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  alr_pkg::status_type status,
   output alr_pkg::cmd_type    cmd
);
   import alr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   always_comb begin
      accept        = start && (state_ff == ST_IDLE);
      state_in      = state_ff;
      cmd.load      = accept;
      cmd.div_start = 1'b0;
      cmd.emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !status.same) begin
               if (status.axis) begin
                  state_in = ST_RUN;
               end else begin
                  state_in      = ST_DIV;
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   a_emit_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == ST_RUN)
      else $error("emit outside run state");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last) |=> state_ff == ST_IDLE)
      else $error("run did not end after last beat");
   a_div_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (state_ff == ST_IDLE && cmd.load))
      else $error("division started outside accept");
   a_same_no_work: assert property (@(posedge clock) disable iff (reset)
      (accept && status.same) |=> state_ff == ST_IDLE)
      else $error("degenerate line left idle");

endmodule
